### hw/rtl/variable_partition_allocator_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the partition allocator
// Shared property wrappers used by the RTL assertions.
// ---------------------------------------------------------------------------
`ifndef VARIABLE_PARTITION_ALLOCATOR_CORE_DEFINES_SVH
`define VARIABLE_PARTITION_ALLOCATOR_CORE_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define VPA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define VPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/vpa_pkg.sv
// ---------------------------------------------------------------------------
// vpa_pkg
// Types and constants shared by the partition allocator.
// ---------------------------------------------------------------------------
package vpa_pkg;

  localparam int MaxSegments = 64;
  localparam int AddrBits    = 16;
  localparam int IdxBits     = $clog2(MaxSegments);
  localparam int CntBits     = $clog2(MaxSegments + 1);
  localparam int SegBits     = 2 * AddrBits + 1 + 16;

  localparam logic [0:0] FUNC_ALLOC = 1'b0;
  localparam logic [0:0] FUNC_FREE  = 1'b1;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic [0:0] CFG_TOTAL_SIZE = 1'b0;
  localparam logic [0:0] CFG_FIT_MODE   = 1'b1;

  localparam logic [2:0] ST_ALLOC_OK = 3'd0;
  localparam logic [2:0] ST_NO_FIT   = 3'd1;
  localparam logic [2:0] ST_FREED    = 3'd2;
  localparam logic [2:0] ST_NO_OWNER = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [AddrBits-1:0] start;
    logic [AddrBits-1:0] size;
    logic                free;
    logic [15:0]         owner;
  } seg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SPLIT,
    S_REL_RD,
    S_REL,
    S_MRG_RD,
    S_MRG,
    S_MRG_END,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [AddrBits-1:0] address;
    logic [15:0]         given_id;
  } result_t;

endpackage

### hw/rtl/vpa_ram.sv
// ---------------------------------------------------------------------------
// vpa_ram
// Generic synchronous RAM with one write port and one registered read port.
// ---------------------------------------------------------------------------
module vpa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/vpa_ctrl.sv
// ---------------------------------------------------------------------------
// vpa_ctrl
// Sequencer: search, shift-insert, release and merge passes over the table.
// ---------------------------------------------------------------------------
module vpa_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         func,
  input  logic [vpa_pkg::AddrBits-1:0] req_size,
  input  logic [15:0]                  proc_id,
  input  logic [1:0]                   fit_mode,
  input  logic                         cfg_init,
  input  logic [vpa_pkg::AddrBits-1:0] cfg_size,
  output logic                         busy,
  output logic                         done,
  output vpa_pkg::result_t             result,
  output logic                         mem_we,
  output logic [vpa_pkg::IdxBits-1:0]  mem_waddr,
  output vpa_pkg::seg_t                mem_wdata,
  output logic [vpa_pkg::IdxBits-1:0]  mem_raddr,
  input  vpa_pkg::seg_t                mem_rdata
);
  import vpa_pkg::*;

  state_t              state_r, state_nxt;
  logic [CntBits-1:0]  count_r, count_nxt;
  logic [15:0]         next_id_r, next_id_nxt;
  logic [CntBits-1:0]  i_r, i_nxt;
  logic [CntBits-1:0]  w_r, w_nxt;
  logic                pick_v_r, pick_v_nxt;
  logic [IdxBits-1:0]  pick_r, pick_nxt;
  seg_t                pseg_r, pseg_nxt;   // picked segment / merge accumulator
  logic                found_r, found_nxt;
  logic                func_r, func_nxt;
  logic [AddrBits-1:0] size_r, size_nxt;
  logic [15:0]         pid_r, pid_nxt;
  result_t             res_r, res_nxt;
  logic                better;

  assign busy   = (state_r != S_IDLE);
  assign done   = (state_r == S_DONE);
  assign result = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= CntBits'(1);
      next_id_r <= 16'd1;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      next_id_r <= next_id_nxt;
    end
    i_r      <= i_nxt;
    w_r      <= w_nxt;
    pick_v_r <= pick_v_nxt;
    pick_r   <= pick_nxt;
    pseg_r   <= pseg_nxt;
    found_r  <= found_nxt;
    func_r   <= func_nxt;
    size_r   <= size_nxt;
    pid_r    <= pid_nxt;
    res_r    <= res_nxt;
  end

  always_comb begin
    better = 1'b0;
    if (!pick_v_r) begin
      better = 1'b1;
    end else if (fit_mode == FIT_BEST) begin
      better = mem_rdata.size < pseg_r.size;
    end else if (fit_mode == FIT_WORST) begin
      better = mem_rdata.size > pseg_r.size;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    next_id_nxt = next_id_r;
    i_nxt       = i_r;
    w_nxt       = w_r;
    pick_v_nxt  = pick_v_r;
    pick_nxt    = pick_r;
    pseg_nxt    = pseg_r;
    found_nxt   = found_r;
    func_nxt    = func_r;
    size_nxt    = size_r;
    pid_nxt     = pid_r;
    res_nxt     = res_r;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = mem_rdata;
    mem_raddr   = i_r[IdxBits-1:0];

    if (cfg_init) begin
      mem_we          = 1'b1;
      mem_waddr       = '0;
      mem_wdata.start = '0;
      mem_wdata.size  = cfg_size;
      mem_wdata.free  = 1'b1;
      mem_wdata.owner = '0;
      count_nxt       = CntBits'(1);
      next_id_nxt     = 16'd1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt   = func;
          size_nxt   = req_size;
          pid_nxt    = proc_id;
          i_nxt      = '0;
          pick_v_nxt = 1'b0;
          found_nxt  = 1'b0;
          res_nxt    = '0;
          if (func == FUNC_FREE) begin
            state_nxt = S_REL_RD;
          end else if (req_size == '0) begin
            res_nxt.status = ST_FULL;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_SRCH_RD;
          end
        end
      end
      S_SRCH_RD: begin
        if (i_r >= count_r) begin
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        state_nxt = S_SRCH_RD;
        i_nxt     = i_r + 1'b1;
        if (mem_rdata.free && mem_rdata.size >= size_r && better) begin
          pick_v_nxt = 1'b1;
          pick_nxt   = i_r[IdxBits-1:0];
          pseg_nxt   = mem_rdata;
          if (fit_mode == FIT_FIRST) begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        if (pick_v_r && pseg_r.size != size_r && count_r >= CntBits'(MaxSegments)) begin
          res_nxt.status = ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          res_nxt.given_id = next_id_r;
          next_id_nxt      = (next_id_r == 16'hFFFF) ? 16'd1 : next_id_r + 16'd1;
          if (!pick_v_r) begin
            res_nxt.status = ST_NO_FIT;
            state_nxt      = S_DONE;
          end else begin
            res_nxt.status  = ST_ALLOC_OK;
            res_nxt.address = pseg_r.start;
            if (pseg_r.size != size_r) begin
              i_nxt     = count_r;
              state_nxt = S_SHIFT_RD;
            end else begin
              state_nxt = S_SPLIT;
            end
          end
        end
      end
      // move entries up one place, from the top down to pick+1
      S_SHIFT_RD: begin
        mem_raddr = IdxBits'(i_r - 1'b1);
        if (i_r > {1'b0, pick_r} + CntBits'(1)) begin
          state_nxt = S_SHIFT_WR;
        end else begin
          state_nxt = S_SPLIT;
        end
      end
      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = i_r[IdxBits-1:0];
        mem_wdata = mem_rdata;
        i_nxt     = i_r - 1'b1;
        state_nxt = S_SHIFT_RD;
      end
      // write the used part; remainder goes in via the MRG_END state below
      S_SPLIT: begin
        mem_we          = 1'b1;
        mem_waddr       = pick_r;
        mem_wdata       = pseg_r;
        mem_wdata.free  = 1'b0;
        mem_wdata.owner = res_r.given_id;
        if (pseg_r.size != size_r) begin
          mem_wdata.size   = size_r;
          pseg_nxt.start   = pseg_r.start + size_r;
          pseg_nxt.size    = pseg_r.size - size_r;
          pseg_nxt.free    = 1'b1;
          pseg_nxt.owner   = '0;
          size_nxt         = pseg_r.size - size_r;
          pick_nxt         = pick_r + 1'b1;
          count_nxt        = count_r + 1'b1;
          res_nxt.given_id = res_r.given_id;
          state_nxt        = S_MRG_END;   // reused: writes remainder
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_REL_RD: begin
        if (i_r >= count_r) begin
          if (found_r) begin
            i_nxt     = CntBits'(1);
            w_nxt     = '0;
            state_nxt = S_MRG_RD;
            mem_raddr = '0;
          end else begin
            res_nxt.status = ST_NO_OWNER;
            state_nxt      = S_DONE;
          end
        end else begin
          state_nxt = S_REL;
        end
      end
      S_REL: begin
        if (!mem_rdata.free && mem_rdata.owner == pid_r) begin
          mem_we          = 1'b1;
          mem_waddr       = i_r[IdxBits-1:0];
          mem_wdata.free  = 1'b1;
          mem_wdata.owner = '0;
          found_nxt       = 1'b1;
        end
        i_nxt     = i_r + 1'b1;
        state_nxt = S_REL_RD;
      end
      // compaction: accumulator holds entry w; mem read of entry 0 lands now
      S_MRG_RD: begin
        pseg_nxt  = mem_rdata;
        state_nxt = S_MRG;
        mem_raddr = i_r[IdxBits-1:0];
      end
      S_MRG: begin
        // mem_rdata holds entry i when i < count
        if (i_r >= count_r) begin
          mem_we    = 1'b1;
          mem_waddr = w_r[IdxBits-1:0];
          mem_wdata = pseg_r;
          count_nxt = w_r + 1'b1;
          res_nxt.status = ST_FREED;
          state_nxt = S_DONE;
        end else begin
          mem_raddr = IdxBits'(i_r + 1'b1);
          i_nxt     = i_r + 1'b1;
          if (pseg_r.free && mem_rdata.free) begin
            pseg_nxt.size = pseg_r.size + mem_rdata.size;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = w_r[IdxBits-1:0];
            mem_wdata = pseg_r;
            w_nxt     = w_r + 1'b1;
            pseg_nxt  = mem_rdata;
          end
        end
      end
      S_MRG_END: begin
        mem_we    = 1'b1;
        mem_waddr = pick_r;
        mem_wdata = pseg_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

### hw/rtl/variable_partition_allocator_core.sv
// ---------------------------------------------------------------------------
// variable_partition_allocator_core
// First/best/worst-fit segment allocator over a RAM-held segment table.
// ---------------------------------------------------------------------------
//  channel | direction | fields
//  in_     | input     | func, req_size, proc_id
//  out_    | output    | status, address, given_id
//  cfg_    | write     | 0 total_size, 1 fit_mode
//
//  One transaction at a time. Allocate: scan the segments, then move entries
//  up one place on a split. Free: a release pass over the segments, then a
//  merge pass. The table RAM (one read, one write per cycle) sets the pace
//  of these passes.
//  Reset is synchronous; the table RAM needs no clear (entry 0 is written).
//  A waiting result in the output register blocks the next input.
module variable_partition_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [15:0] in_req_size,
  input  logic [15:0] in_proc_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_address,
  output logic [15:0] out_given_id,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import vpa_pkg::*;
`include "variable_partition_allocator_core_defines.svh"

  logic [1:0]     fit_mode_r;
  logic           init_pend_r;   // entry 0 rewrite after reset
  logic           out_valid_r;
  result_t        out_r;
  logic           busy, done, start, cfg_init;
  result_t        result;
  logic           mem_we, c_we;
  logic [IdxBits-1:0] mem_waddr, c_waddr, mem_raddr;
  seg_t           mem_wdata, c_wdata, mem_rdata;
  logic [AddrBits-1:0] init_size;

  assign in_ready = !busy && !out_valid_r && !init_pend_r;
  assign start    = in_valid && in_ready;
  assign cfg_init = (cfg_we && cfg_index == CFG_TOTAL_SIZE) || init_pend_r;
  assign init_size = init_pend_r ? 16'hFFFF : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r  <= FIT_FIRST;
      init_pend_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      init_pend_r <= 1'b0;
      if (cfg_we && cfg_index == CFG_FIT_MODE && cfg_data[1:0] != 2'd3) begin
        fit_mode_r <= cfg_data[1:0];
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (done) begin
      out_r <= result;
    end
  end

  vpa_ctrl u_ctrl (
    .clk, .rst_n, .start,
    .func(in_func), .req_size(in_req_size), .proc_id(in_proc_id),
    .fit_mode(fit_mode_r), .cfg_init, .cfg_size(init_size),
    .busy, .done, .result,
    .mem_we(c_we), .mem_waddr(c_waddr), .mem_wdata(c_wdata),
    .mem_raddr, .mem_rdata
  );

  assign mem_we    = c_we;
  assign mem_waddr = c_waddr;
  assign mem_wdata = c_wdata;

  vpa_ram #(.Width(SegBits), .Depth(MaxSegments)) u_table (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  assign out_valid    = out_valid_r;
  assign out_status   = out_r.status;
  assign out_address  = out_r.address;
  assign out_given_id = out_r.given_id;

  `VPA_ASSERT_IMP(a_no_accept_busy, busy, !in_ready, "input taken while busy")
  `VPA_ASSERT_NEXT(a_done_valid, done, out_valid, "result lost")
  `VPA_ASSERT_IMP(a_status_range, out_valid, out_status <= ST_FULL, "bad status")
endmodule

### sim/variable_partition_allocator_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// variable_partition_allocator_core_tb
// Drives allocate/free transactions through several fit modes and memory
// sizes, predicts each result from a local segment table model and checks
// every result field against the oldest expected result.
// ---------------------------------------------------------------------------
module variable_partition_allocator_core_tb;
  import vpa_pkg::*;

  typedef struct {
    logic [15:0] start;
    logic [15:0] size;
    bit          free;
    logic [15:0] owner;
  } part_t;

  // one expected result per accepted transaction
  class alloc_scoreboard;
    part_t       parts[MaxSegments];
    int          part_cnt;
    logic [15:0] id_ctr;
    logic [15:0] mem_size;
    logic [1:0]  policy;
    result_t     pending[$];
    int          errors;

    function void init_table();
      parts[0].start = 0;
      parts[0].size  = mem_size;
      parts[0].free  = 1;
      parts[0].owner = 0;
      part_cnt = 1;
      id_ctr   = 1;
    endfunction

    function void reset_state();
      mem_size = 16'hFFFF;
      policy   = FIT_FIRST;
      errors   = 0;
      init_table();
    endfunction

    function void write_reg(logic idx, logic [15:0] val);
      if (idx == CFG_TOTAL_SIZE) begin
        mem_size = val;
        init_table();
      end else if (val[1:0] != 2'd3) begin
        policy = val[1:0];
      end
    endfunction

    function result_t predict_alloc(logic [15:0] want);
      result_t r;
      int pick;
      r = '0;
      pick = -1;
      if (want == 0) begin
        r.status = ST_FULL;
        return r;
      end
      for (int i = 0; i < part_cnt; i++) begin
        if (!parts[i].free || parts[i].size < want) continue;
        if (policy == FIT_FIRST) begin
          pick = i;
          break;
        end
        if (pick < 0 || (policy == FIT_BEST && parts[i].size < parts[pick].size) ||
            (policy == FIT_WORST && parts[i].size > parts[pick].size))
          pick = i;
      end
      if (pick >= 0 && parts[pick].size != want && part_cnt >= MaxSegments) begin
        r.status = ST_FULL;
        return r;
      end
      r.given_id = id_ctr;
      id_ctr = (id_ctr == 16'hFFFF) ? 16'd1 : id_ctr + 16'd1;
      if (pick < 0) begin
        r.status = ST_NO_FIT;
        return r;
      end
      if (parts[pick].size != want) begin
        for (int j = part_cnt; j > pick + 1; j--) parts[j] = parts[j-1];
        parts[pick+1].start = parts[pick].start + want;
        parts[pick+1].size  = parts[pick].size - want;
        parts[pick+1].free  = 1;
        parts[pick+1].owner = 0;
        parts[pick].size = want;
        part_cnt++;
      end
      parts[pick].free  = 0;
      parts[pick].owner = r.given_id;
      r.status  = ST_ALLOC_OK;
      r.address = parts[pick].start;
      return r;
    endfunction

    function result_t predict_release(logic [15:0] pid);
      result_t r;
      bit hit;
      int w;
      r = '0;
      hit = 0;
      for (int i = 0; i < part_cnt; i++)
        if (!parts[i].free && parts[i].owner == pid) begin
          parts[i].free  = 1;
          parts[i].owner = 0;
          hit = 1;
        end
      if (!hit) begin
        r.status = ST_NO_OWNER;
        return r;
      end
      w = 0;
      for (int i = 1; i < part_cnt; i++) begin
        if (parts[w].free && parts[i].free) parts[w].size = parts[w].size + parts[i].size;
        else begin
          w++;
          parts[w] = parts[i];
        end
      end
      part_cnt = w + 1;
      r.status = ST_FREED;
      return r;
    endfunction

    function void note_input(logic fn, logic [15:0] sz, logic [15:0] pid);
      result_t r;
      r = (fn == FUNC_ALLOC) ? predict_alloc(sz) : predict_release(pid);
      pending = {pending, r};
    endfunction

    task report(string what);
      $display("MISMATCH: %s", what);
      errors++;
    endtask

    task check_result(logic [2:0] st, logic [15:0] ad, logic [15:0] gid);
      result_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result st=%0d", st));
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) report($sformatf("status %0d exp %0d", st, e.status));
      if (ad !== e.address) report($sformatf("address %0d exp %0d", ad, e.address));
      if (gid !== e.given_id) report($sformatf("given_id %0d exp %0d", gid, e.given_id));
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0, in_func = 0;
  logic [15:0] in_req_size = 0, in_proc_id = 0;
  logic        in_ready, out_valid;
  logic        out_ready = 0;
  logic [2:0]  out_status;
  logic [15:0] out_address, out_given_id;
  logic        cfg_we = 0, cfg_index = 0;
  logic [15:0] cfg_data = 0;

  alloc_scoreboard sb;
  bit quiet;       // when set, neither side idles
  bit done_drive;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  variable_partition_allocator_core dut (.*);

  // result side: random stall, check on each accepted transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_status, out_address, out_given_id);
    out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 12);
  end

  // valid stays up after acceptance; drain() or an idle in the next call drops it
  task send_item(logic fn, logic [15:0] sz, logic [15:0] pid);
    while (!quiet && $urandom_range(99) < 12) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid    <= 1;
    in_func     <= fn;
    in_req_size <= sz;
    in_proc_id  <= pid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(fn, sz, pid);
  endtask

  task drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);  // short idle gap before any config write
  endtask

  task write_cfg(logic idx, logic [15:0] val);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // random ids biased toward ids recently handed out
  function logic [15:0] pick_id();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return (sb.id_ctr > 40) ? 16'(sb.id_ctr - $urandom_range(1, 40))
                            : 16'($urandom_range(0, 40));
  endfunction

  function logic [15:0] pick_size(logic [15:0] tot);
    case ($urandom_range(9))
      0:       return 16'($urandom);
      1:       return 0;
      default: return 16'($urandom_range(1, (tot > 8 ? tot / 8 : 2)));
    endcase
  endfunction

  task random_phase(int n, logic [15:0] tot);
    for (int k = 0; k < n; k++) begin
      quiet = (k >= n / 2 && k < n / 2 + 40);
      if ($urandom_range(2) == 0) send_item(FUNC_FREE, 16'($urandom), pick_id());
      else send_item(FUNC_ALLOC, pick_size(tot), 16'($urandom));
    end
    quiet = 0;
  endtask

  initial begin
    logic [15:0] tot;
    sb = new();
    sb.reset_state();
    quiet = 0;
    done_drive = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset config, extremes, every status
    send_item(FUNC_ALLOC, 0, 16'hFFFF);
    send_item(FUNC_FREE, 16'hFFFF, 0);
    send_item(FUNC_ALLOC, 16'hFFFF, 0);
    send_item(FUNC_ALLOC, 1, 0);
    send_item(FUNC_FREE, 0, 1);
    send_item(FUNC_FREE, 0, 16'hFFFF);
    send_item(FUNC_ALLOC, 100, 0);
    send_item(FUNC_ALLOC, 16'hFFFF, 0);
    drain();
    write_cfg(CFG_FIT_MODE, 16'(FIT_BEST));
    write_cfg(CFG_FIT_MODE, 16'hFFFF);  // mode 3 ignored
    write_cfg(CFG_TOTAL_SIZE, 16'd0);
    send_item(FUNC_ALLOC, 1, 0);
    drain();
    // table full: small memory, many one-unit allocations
    write_cfg(CFG_TOTAL_SIZE, 16'd200);
    for (int k = 0; k < 66; k++) send_item(FUNC_ALLOC, 1, 0);
    send_item(FUNC_ALLOC, 137, 0);  // exact fit of what remains
    send_item(FUNC_FREE, 0, 5);
    drain();
    // failed fits still consume ids
    write_cfg(CFG_TOTAL_SIZE, 16'd1);
    write_cfg(CFG_FIT_MODE, 16'(FIT_WORST));
    for (int k = 0; k < 20; k++) send_item(FUNC_ALLOC, 2, 0);
    send_item(FUNC_ALLOC, 1, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      tot = (ph == 0) ? 16'hFFFF : (ph == 1) ? 16'd1 : 16'($urandom_range(64, 4000));
      write_cfg(CFG_TOTAL_SIZE, tot);
      write_cfg(CFG_FIT_MODE, 16'(ph % 3));
      random_phase(180, tot);
      drain();
    end
    done_drive = 1;
  end

  initial begin
    wait (done_drive);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #40ms;
    $display("Some tests failed");
    $finish;
  end
endmodule

### files.f
+incdir+hw/rtl
hw/rtl/vpa_pkg.sv
hw/rtl/vpa_ram.sv
hw/rtl/vpa_ctrl.sv
hw/rtl/variable_partition_allocator_core.sv
sim/variable_partition_allocator_core_tb.sv
